>>> hw/rtl/crc8fr_pkg.sv
// Shared types, constants and codes for the CRC-8 framed packet receiver.
package crc8fr_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [7:0] CRC_POLY        = 8'h8C;
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [3:0] {
        S_SYNC1,
        S_SYNC2,
        S_TYPE,
        S_SEQ,
        S_LEN,
        S_DATA,
        S_CRC,
        S_RD,
        S_WR
    } t_state;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } t_crc_cmd;

endpackage

>>> hw/rtl/crc8fr_crc_bitser.sv
// Bit-serial reflected CRC-8 unit: one bit of the byte is folded in per cycle.
module crc8fr_crc_bitser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crc8fr_pkg::t_crc_cmd i_cmd,
    output logic                o_busy,
    output logic [7:0]          o_crc
);
    import crc8fr_pkg::*;

    logic [7:0] r_crc, n_crc;
    logic [7:0] r_sh;
    logic [2:0] r_cnt;
    logic       r_busy;
    logic       fb;
    logic [7:0] crc_base;

    // A new command optionally restarts the CRC from zero before its first bit.
    assign crc_base = (i_cmd.start && i_cmd.clear) ? 8'h00 : r_crc;
    assign fb       = r_crc[0] ^ r_sh[0];
    assign n_crc    = {1'b0, r_crc[7:1]} ^ (fb ? CRC_POLY : 8'h00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= 8'h00;
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_cmd.start) begin
            r_crc  <= crc_base;
            r_busy <= 1'b1;
            r_cnt  <= 3'd7;
        end else if (r_busy) begin
            r_crc <= n_crc;
            r_cnt <= r_cnt - 3'd1;
            if (r_cnt == 3'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sh <= i_cmd.data;
        end else if (r_busy) begin
            r_sh <= {1'b0, r_sh[7:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_crc;

endmodule

>>> hw/rtl/crc8fr_store.sv
// Payload memory: one write port and one registered read port.
module crc8fr_store #(
    parameter int DEPTH = crc8fr_pkg::MAX_PAYLOAD_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/crc8_framed_packet_receiver.sv
// Top level: sync hunt, header and payload capture, CRC check and result emission.
// A sync or CRC byte is taken once the bit-serial CRC unit is idle; a type,
// sequence, length or data byte holds off the next until the CRC unit folds it in.
// After a matching CRC byte each result is read from the payload memory (S_RD)
// and registered in S_WR once the result register is free, one result at a time.
// Reset is synchronous and active low; it clears control, header and CRC state
// and restores the sync bytes; the payload memory is not cleared.
module crc8_framed_packet_receiver #(
    parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [crc8fr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_frame_type,
    output logic [7:0]                     o_frame_seq,
    output logic [5:0]                     o_payload_len,
    output logic                           o_has_payload,
    output logic [4:0]                     o_byte_index,
    output logic [7:0]                     o_payload_byte,
    output logic                           o_last_of_frame
);
    import crc8fr_pkg::*;

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    t_state r_state, n_state;

    logic [7:0]       r_sync_first, r_sync_second;
    logic [7:0]       r_type, r_seq;
    logic [LEN_W-1:0] r_len, r_fill, r_idx;

    logic             r_ovalid;
    logic [7:0]       r_o_type, r_o_seq, r_o_byte;
    logic [5:0]       r_o_len;
    logic             r_o_has, r_o_last;
    logic [4:0]       r_o_idx;

    t_crc_cmd   crc_cmd;
    logic       crc_busy;
    logic [7:0] crc_val;
    logic [7:0] rd_data;

    logic in_acc, len_ok, fill_last, emit_last, slot_free, load_out, mem_we;

    assign in_acc    = i_in_valid && o_in_ready;
    assign len_ok    = (i_in_byte <= MAX_LEN);
    assign fill_last = ((LEN_W+1)'(r_fill) + (LEN_W+1)'(1)) >= (LEN_W+1)'(r_len);
    assign emit_last = (r_len == '0) ||
                       (((LEN_W+1)'(r_idx) + (LEN_W+1)'(1)) == (LEN_W+1)'(r_len));
    assign slot_free = !r_ovalid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SYNC1: if (in_acc && (i_in_byte == r_sync_first)) n_state = S_SYNC2;
            S_SYNC2: begin
                if (in_acc) begin
                    n_state = (i_in_byte == r_sync_second) ? S_TYPE : S_SYNC1;
                end
            end
            S_TYPE: if (in_acc) n_state = S_SEQ;
            S_SEQ:  if (in_acc) n_state = S_LEN;
            S_LEN: begin
                if (in_acc) begin
                    if (!len_ok) begin
                        n_state = S_SYNC1;
                    end else begin
                        n_state = (i_in_byte == 8'h00) ? S_CRC : S_DATA;
                    end
                end
            end
            S_DATA: if (in_acc && fill_last) n_state = S_CRC;
            S_CRC: begin
                if (in_acc) begin
                    n_state = (i_in_byte == crc_val) ? S_RD : S_SYNC1;
                end
            end
            S_RD: n_state = S_WR;
            S_WR: if (slot_free) n_state = emit_last ? S_SYNC1 : S_RD;
            default: n_state = S_SYNC1;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        o_in_ready    = 1'b0;
        crc_cmd.start = 1'b0;
        crc_cmd.clear = 1'b0;
        crc_cmd.data  = i_in_byte;
        mem_we        = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            S_SYNC1, S_SYNC2, S_CRC: o_in_ready = !crc_busy;
            S_TYPE: begin
                o_in_ready    = !crc_busy;
                crc_cmd.start = in_acc;
                crc_cmd.clear = 1'b1;
            end
            S_SEQ: begin
                o_in_ready    = !crc_busy;
                crc_cmd.start = in_acc;
            end
            S_LEN: begin
                o_in_ready    = !crc_busy;
                crc_cmd.start = in_acc && len_ok;
            end
            S_DATA: begin
                o_in_ready    = !crc_busy;
                crc_cmd.start = in_acc;
                mem_we        = in_acc;
            end
            S_RD: ;
            S_WR: load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SYNC1;
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_type        <= 8'h00;
            r_seq         <= 8'h00;
            r_len         <= '0;
            r_fill        <= '0;
            r_idx         <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && (r_state == S_TYPE)) r_type <= i_in_byte;
            if (in_acc && (r_state == S_SEQ))  r_seq  <= i_in_byte;
            if (in_acc && (r_state == S_LEN) && len_ok) begin
                r_len  <= LEN_W'(i_in_byte);
                r_fill <= '0;
            end
            if (mem_we) r_fill <= r_fill + LEN_W'(1);
            if (in_acc && (r_state == S_CRC)) r_idx <= '0;
            if (load_out && !emit_last) r_idx <= r_idx + LEN_W'(1);
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload register; an empty frame yields a single all-zero payload result.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_type <= r_type;
            r_o_seq  <= r_seq;
            r_o_len  <= 6'(r_len);
            r_o_has  <= (r_len != '0);
            r_o_idx  <= 5'(r_idx);
            r_o_byte <= (r_len != '0) ? rd_data : 8'h00;
            r_o_last <= emit_last;
        end
    end

    crc8fr_crc_bitser u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_busy  (crc_busy),
        .o_crc   (crc_val)
    );

    crc8fr_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_in_byte),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_out_valid     = r_ovalid;
    assign o_frame_type    = r_o_type;
    assign o_frame_seq     = r_o_seq;
    assign o_payload_len   = r_o_len;
    assign o_has_payload   = r_o_has;
    assign o_byte_index    = r_o_idx;
    assign o_payload_byte  = r_o_byte;
    assign o_last_of_frame = r_o_last;

endmodule

>>> hw/rtl/crc8fr_checker.sv
// Port-level checker for the receiver and its bind to the top level.
module crc8fr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_frame_type,
    input logic [7:0] o_frame_seq,
    input logic [5:0] o_payload_len,
    input logic       o_has_payload,
    input logic [4:0] o_byte_index,
    input logic [7:0] o_payload_byte,
    input logic       o_last_of_frame
);

    // A stalled input transaction stays offered with the same byte.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_byte))
        else $error("input byte withdrawn or changed before it was taken");

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // An empty frame gives one final result with zero index and byte.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_payload |->
            o_last_of_frame && (o_byte_index == 5'd0) && (o_payload_byte == 8'h00)
            && (o_payload_len == 6'd0))
        else $error("malformed empty-frame result");

    // A payload result lies inside the frame, and a non-final one implies a payload.
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_has_payload || !o_last_of_frame) |->
            o_has_payload && (6'(o_byte_index) < o_payload_len))
        else $error("payload index outside the frame");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind crc8_framed_packet_receiver crc8fr_checker u_crc8fr_checker (.*);

>>> tb/crc8_framed_packet_receiver_test.sv
// Self-checking testbench for the CRC-8 framed packet receiver.
module crc8_framed_packet_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fr_pkg::*;

    localparam int RX_MAX         = MAX_PAYLOAD_DEF;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [7:0] frame_seq;
        logic [5:0] len;
        logic       has;
        logic [4:0] idx;
        logic [7:0] data;
        logic       last;
    } t_delivery;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_SYNC_FIRST;
    logic [7:0]           cfg_data = 8'h00;
    logic                 in_valid = 1'b0;
    logic [7:0]           in_byte = 8'h00;
    logic                 out_ready = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [7:0]           o_frame_type;
    logic [7:0]           o_frame_seq;
    logic [5:0]           o_payload_len;
    logic                 o_has_payload;
    logic [4:0]           o_byte_index;
    logic [7:0]           o_payload_byte;
    logic                 o_last_of_frame;

    crc8_framed_packet_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_frame_type   (o_frame_type),
        .o_frame_seq    (o_frame_seq),
        .o_payload_len  (o_payload_len),
        .o_has_payload  (o_has_payload),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last_of_frame(o_last_of_frame)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Link bytes waiting to be sent and payload deliveries still owed by the block.
    logic [7:0] line_bytes_q[$];
    t_delivery  owed_q[$];

    int bytes_queued    = 0;
    int bytes_accepted  = 0;
    int owed_total      = 0;
    int matched_total   = 0;
    int mismatch_count  = 0;
    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int tx_gap_left     = 0;
    int rx_gap_left     = 0;
    int rx_hold_left    = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int cycle_count     = 0;

    // Receiver model state.
    logic [7:0] rx_sync_first  = SYNC_FIRST_RST;
    logic [7:0] rx_sync_second = SYNC_SECOND_RST;
    t_state     rx_stage       = S_SYNC1;
    logic [7:0] rx_type        = 8'h00;
    logic [7:0] rx_seq         = 8'h00;
    int         rx_len         = 0;
    int         rx_fill        = 0;
    logic [7:0] rx_crc         = 8'h00;
    logic [7:0] rx_store[RX_MAX];

    // Reflected CRC-8, polynomial 0x8C, one byte folded in LSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ CRC_POLY;
            b = b >> 1;
        end
        return crc;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_delivery d;
        case (rx_stage)
            S_SYNC2: begin
                rx_stage = (b == rx_sync_second) ? S_TYPE : S_SYNC1;
            end
            S_TYPE: begin
                rx_type  = b;
                rx_crc   = crc8_byte(8'h00, b);
                rx_stage = S_SEQ;
            end
            S_SEQ: begin
                rx_seq   = b;
                rx_crc   = crc8_byte(rx_crc, b);
                rx_stage = S_LEN;
            end
            S_LEN: begin
                if (int'(b) > RX_MAX) begin
                    rx_stage = S_SYNC1;
                end else begin
                    rx_len   = int'(b);
                    rx_crc   = crc8_byte(rx_crc, b);
                    rx_fill  = 0;
                    rx_stage = (b == 8'h00) ? S_CRC : S_DATA;
                end
            end
            S_DATA: begin
                if (rx_fill < RX_MAX)
                    rx_store[rx_fill] = b;
                rx_fill++;
                rx_crc = crc8_byte(rx_crc, b);
                if (rx_fill >= rx_len)
                    rx_stage = S_CRC;
            end
            S_CRC: begin
                rx_stage = S_SYNC1;
                if (rx_crc == b) begin
                    d.frame_type = rx_type;
                    d.frame_seq  = rx_seq;
                    d.len        = rx_len[5:0];
                    if (rx_len == 0) begin
                        d.has  = 1'b0;
                        d.idx  = 5'd0;
                        d.data = 8'h00;
                        d.last = 1'b1;
                        owed_q.push_back(d);
                        owed_total++;
                    end else begin
                        for (int i = 0; i < rx_len && i < RX_MAX; i++) begin
                            d.has  = 1'b1;
                            d.idx  = i[4:0];
                            d.data = rx_store[i];
                            d.last = (i + 1 == rx_len);
                            owed_q.push_back(d);
                            owed_total++;
                        end
                    end
                end
            end
            default: begin
                rx_stage = (b == rx_sync_first) ? S_SYNC2 : S_SYNC1;
            end
        endcase
    endtask

    // Link driver: one byte per transaction, random idle bursts between them.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            tx_gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                deframe_byte(in_byte);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (tx_gap_left != 0) begin
                    tx_gap_left <= tx_gap_left - 1;
                    in_valid    <= 1'b0;
                end else if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
                    tx_gap_left <= $urandom_range(0, 16);
                    in_valid    <= 1'b0;
                end else if (line_bytes_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_byte  <= line_bytes_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (holds_served != holds_requested) begin
            rx_hold_left <= RX_HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // Result monitor and checker.
    always @(posedge i_clk) begin
        t_delivery got;
        t_delivery want;
        if (!rst_n) begin
            out_ready   <= 1'b0;
            rx_gap_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = {o_frame_type, o_frame_seq, o_payload_len, o_has_payload,
                       o_byte_index, o_payload_byte, o_last_of_frame};
                if (owed_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected result: type=%02h seq=%02h len=%0d",
                                  " has=%0b idx=%0d byte=%02h last=%0b"},
                                 got.frame_type, got.frame_seq, got.len, got.has,
                                 got.idx, got.data, got.last);
                end else begin
                    want = owed_q.pop_front();
                    matched_total++;
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"mismatch exp: type=%02h seq=%02h len=%0d",
                                      " has=%0b idx=%0d byte=%02h last=%0b"},
                                     want.frame_type, want.frame_seq, want.len,
                                     want.has, want.idx, want.data, want.last);
                            $display({"         got: type=%02h seq=%02h len=%0d",
                                      " has=%0b idx=%0d byte=%02h last=%0b"},
                                     got.frame_type, got.frame_seq, got.len,
                                     got.has, got.idx, got.data, got.last);
                        end
                    end
                end
            end
            if (rx_hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (rx_gap_left != 0) begin
                rx_gap_left <= rx_gap_left - 1;
                out_ready   <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                rx_gap_left <= $urandom_range(0, 16);
                out_ready   <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        line_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic send_frame(input int len, input logic [7:0] ftype,
                              input logic [7:0] fseq, input logic [7:0] crc_flip);
        logic [7:0] crc;
        logic [7:0] b;
        send_byte(rx_sync_first);
        send_byte(rx_sync_second);
        send_byte(ftype);
        send_byte(fseq);
        send_byte(len[7:0]);
        crc = crc8_byte(8'h00, ftype);
        crc = crc8_byte(crc, fseq);
        crc = crc8_byte(crc, len[7:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
            crc = crc8_byte(crc, b);
        end
        send_byte(crc ^ crc_flip);
    endtask

    task automatic send_mixed_traffic(input int budget);
        int start;
        int pick;
        int len;
        logic [7:0] b;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = $urandom_range(0, 99);
                if (len < 60)
                    len = $urandom_range(0, 4);
                else if (len < 92)
                    len = $urandom_range(5, RX_MAX - 1);
                else
                    len = RX_MAX;
                // Most frames carry a correct check byte; some are corrupted.
                send_frame(len, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           (pick < 58) ? 8'h00 : 8'($urandom_range(1, 255)));
            end else if (pick < 78) begin
                send_byte(rx_sync_first);
                do b = 8'($urandom_range(0, 255)); while (b == rx_sync_second);
                send_byte(b);
            end else if (pick < 86) begin
                send_byte(rx_sync_first);
                send_byte(rx_sync_second);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(($urandom_range(0, 3) == 0) ?
                          8'hFF : 8'($urandom_range(RX_MAX + 1, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == rx_sync_first);
                    send_byte(b);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || matched_total != owed_total)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx == CFG_SYNC_FIRST)
            rx_sync_first = val;
        else
            rx_sync_second = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
        write_reg(CFG_SYNC_FIRST, first);
        write_reg(CFG_SYNC_SECOND, second);
    endtask

    initial begin
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed part with the reset sync bytes.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND_RST);
        send_frame(0, 8'hFF, 8'h00, 8'h00);
        send_frame(1, 8'h00, 8'hFF, 8'h01);
        // A repeated first sync byte is a wrong second byte and is not retried.
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_byte(SYNC_FIRST_RST);
        send_byte(SYNC_SECOND_RST);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'(RX_MAX + 1));
        wait_drained();

        set_sync(8'h00, 8'hFF);
        tx_idle_pct = 15;
        rx_idle_pct = 25;
        send_mixed_traffic(30);
        wait_drained();

        // Hold the receiver while a full-size and a 12-byte frame stream in, with no sender gaps.
        tx_idle_pct = 0;
        rx_idle_pct = 10;
        holds_requested++;
        send_frame(RX_MAX, 8'hA5, 8'h5A, 8'h00);
        send_frame(12, 8'h3C, 8'hC3, 8'h00);
        wait_drained();

        set_sync(8'hFF, 8'h00);
        tx_idle_pct = 25;
        rx_idle_pct = 15;
        send_mixed_traffic(25);
        wait_drained();

        set_sync(8'h3C, 8'h3C);
        tx_idle_pct = 10;
        rx_idle_pct = 30;
        send_mixed_traffic(25);
        wait_drained();

        set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_mixed_traffic(25);
        wait_drained();

        mismatch_count += owed_q.size();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
